// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Depends on nothing; every other file of the block imports it.
package spq_pkg;

    localparam int PRIO_W        = 16;
    localparam int ITEM_PAYLOAD_W = 32;
    localparam int COUNT_OUT_W   = 5;

    localparam int DEPTH_DEFAULT         = 16;
    localparam int PAYLOAD_WIDTH_DEFAULT = 32;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_kind_t;

    // One request transaction.
    typedef struct packed
    {
        op_kind_t                   kind;
        logic signed [PRIO_W-1:0]   priority_req;
        logic [ITEM_PAYLOAD_W-1:0]  payload;
    } req_t;

    // One response transaction.
    typedef struct packed
    {
        logic                       removed_valid;
        logic signed [PRIO_W-1:0]   removed_priority;
        logic [ITEM_PAYLOAD_W-1:0]  removed_payload;
        logic                       empty_error;
        logic                       full_error;
        logic                       head_valid;
        logic signed [PRIO_W-1:0]   head_priority;
        logic [ITEM_PAYLOAD_W-1:0]  head_payload;
        logic [COUNT_OUT_W-1:0]     entry_count;
    } rsp_t;

    // Broadcast command to every cell of the row.
    typedef struct packed
    {
        logic ins;
        logic del;
    } cell_cmd_t;

    // Status a cell hands to its right-hand neighbor.
    typedef struct packed
    {
        logic occupied;
        logic keep;
    } cell_link_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One cell of the sorted row: holds one entry and its occupied flag.
// Depends on spq_pkg for the command and link types.
module spq_cell #(
    parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq_pkg::cell_cmd_t                cmd,
    input  logic signed [spq_pkg::PRIO_W-1:0] new_prio,
    input  logic [PAYLOAD_WIDTH-1:0]          new_payload,
    input  spq_pkg::cell_link_t               left_link,
    input  logic signed [spq_pkg::PRIO_W-1:0] left_prio,
    input  logic [PAYLOAD_WIDTH-1:0]          left_payload,
    input  logic                              right_occupied,
    input  logic signed [spq_pkg::PRIO_W-1:0] right_prio,
    input  logic [PAYLOAD_WIDTH-1:0]          right_payload,
    output spq_pkg::cell_link_t               link,
    output logic signed [spq_pkg::PRIO_W-1:0] prio,
    output logic [PAYLOAD_WIDTH-1:0]          payload,
    output logic                              occupied_next,
    output logic signed [spq_pkg::PRIO_W-1:0] prio_next,
    output logic [PAYLOAD_WIDTH-1:0]          payload_next
);
    import spq_pkg::*;

    logic                      occupied_reg;
    logic signed [PRIO_W-1:0]  prio_reg;
    logic [PAYLOAD_WIDTH-1:0]  payload_reg;

    // A cell keeps its entry on insert only when it outranks the new one.
    assign link.occupied = occupied_reg;
    assign link.keep     = occupied_reg && (prio_reg > new_prio);

    always_comb
    begin
        occupied_next = occupied_reg;
        prio_next     = prio_reg;
        payload_next  = payload_reg;
        if (cmd.ins)
        begin
            occupied_next = occupied_reg | left_link.occupied;
            if (!link.keep)
            begin
                if (left_link.keep)
                begin
                    prio_next    = new_prio;
                    payload_next = new_payload;
                end
                else
                begin
                    prio_next    = left_prio;
                    payload_next = left_payload;
                end
            end
        end
        else if (cmd.del)
        begin
            occupied_next = right_occupied;
            prio_next     = right_prio;
            payload_next  = right_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
        end
        else
        begin
            occupied_reg <= occupied_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: a row of spq_cell instances and
// the response register. Depends on spq_pkg and spq_cell.
module sorted_priority_queue #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEFAULT,
    parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp
);
    // The queue is a row of DEPTH identical cells kept sorted with the
    // highest priority in cell 0. Every request transaction is an insert or
    // a delete of the head, and each one produces exactly one response
    // transaction. Throughput is one transaction per clock while the response
    // side does not stall: the operation is broadcast to all cells at once,
    // each cell compares the new priority with its own and either holds,
    // captures the new entry, or takes its neighbor's entry, so the whole row
    // changes at once. Responses are registered. An insert goes ahead of every
    // entry of lower or equal priority, so entries of equal priority leave
    // last in, first out. A delete on an empty queue changes nothing and sets
    // empty_error; an insert into a full queue is dropped and sets
    // full_error. Each response reports the head and the entry count as they
    // stand after the operation. The request side is stalled only while a
    // response waits that the consumer has not taken.
    import spq_pkg::*;

    localparam int COUNT_W = $clog2(DEPTH + 1);

    cell_link_t               link_out   [DEPTH];
    cell_link_t               link_in    [DEPTH];
    logic signed [PRIO_W-1:0] prio_q     [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] payload_q  [DEPTH];
    logic signed [PRIO_W-1:0] left_prio  [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] left_pay   [DEPTH];
    logic                     right_occ  [DEPTH];
    logic signed [PRIO_W-1:0] right_prio [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] right_pay  [DEPTH];
    logic                     occ_next   [DEPTH];
    logic signed [PRIO_W-1:0] prio_next  [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_next   [DEPTH];

    logic                     accept;
    logic                     full;
    logic                     empty;
    cell_cmd_t                cmd;
    logic [PAYLOAD_WIDTH-1:0] new_payload;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    // A transaction is taken whenever the response slot is free or drains now.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // The row is filled from cell 0 upward, so the end cells tell the fill state.
    assign full  = link_out[DEPTH-1].occupied;
    assign empty = !link_out[0].occupied;

    assign cmd.ins     = accept && (req.kind == OP_INSERT) && !full;
    assign cmd.del     = accept && (req.kind == OP_DELETE) && !empty;
    assign new_payload = PAYLOAD_WIDTH'(req.payload);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            // Cell 0 sees a virtual left neighbor that is always full and
            // always outranks, so the new entry lands there when nothing
            // in the row outranks it.
            if (gi == 0)
            begin : g_first
                assign link_in[gi].occupied = 1'b1;
                assign link_in[gi].keep     = 1'b1;
                assign left_prio[gi]        = '0;
                assign left_pay[gi]         = '0;
            end
            else
            begin : g_inner
                assign link_in[gi]   = link_out[gi-1];
                assign left_prio[gi] = prio_q[gi-1];
                assign left_pay[gi]  = payload_q[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_occ[gi]  = 1'b0;
                assign right_prio[gi] = '0;
                assign right_pay[gi]  = '0;
            end
            else
            begin : g_body
                assign right_occ[gi]  = link_out[gi+1].occupied;
                assign right_prio[gi] = prio_q[gi+1];
                assign right_pay[gi]  = payload_q[gi+1];
            end

            spq_cell #(
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .cmd            (cmd),
                .new_prio       (req.priority_req),
                .new_payload    (new_payload),
                .left_link      (link_in[gi]),
                .left_prio      (left_prio[gi]),
                .left_payload   (left_pay[gi]),
                .right_occupied (right_occ[gi]),
                .right_prio     (right_prio[gi]),
                .right_payload  (right_pay[gi]),
                .link           (link_out[gi]),
                .prio           (prio_q[gi]),
                .payload        (payload_q[gi]),
                .occupied_next  (occ_next[gi]),
                .prio_next      (prio_next[gi]),
                .payload_next   (pay_next[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.del)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    // The response is built from the head before the step (removed entry)
    // and from the head the row will hold after the step.
    always_comb
    begin
        rsp_next = '0;
        rsp_next.empty_error = accept && (req.kind == OP_DELETE) && empty;
        rsp_next.full_error  = accept && (req.kind == OP_INSERT) && full;
        if (cmd.del)
        begin
            rsp_next.removed_valid    = 1'b1;
            rsp_next.removed_priority = prio_q[0];
            rsp_next.removed_payload  = ITEM_PAYLOAD_W'(64'(payload_q[0]));
        end
        if (occ_next[0])
        begin
            rsp_next.head_valid    = 1'b1;
            rsp_next.head_priority = prio_next[0];
            rsp_next.head_payload  = ITEM_PAYLOAD_W'(64'(pay_next[0]));
        end
        rsp_next.entry_count = COUNT_OUT_W'(count_next);
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== dv/sorted_priority_queue_tb.sv =====
// Self-checking testbench for sorted_priority_queue: random and directed
// insert/delete transactions, checked against an in-bench sorted-list model.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int PAYLOAD_WIDTH  = PAYLOAD_WIDTH_DEFAULT;
    localparam logic [ITEM_PAYLOAD_W-1:0] STORED_MASK =
        (PAYLOAD_WIDTH >= ITEM_PAYLOAD_W) ? '1 : ((1 << PAYLOAD_WIDTH) - 1);

    // Roughly how many random transactions follow the directed ones.
    localparam int RANDOM_OPS   = 1500;
    // Once this few transactions remain, both sides stop idling.
    localparam int CALM_TAIL    = 200;
    // Cycles allowed for stray responses after the last expected one.
    localparam int SETTLE_CYCLES = 20;
    // Limit on the whole run, with room for the idle bursts on the request side
    // and the stall bursts on the response side.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_PRINTED  = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    sorted_priority_queue #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Transactions waiting to be offered, and responses predicted for the
    // transactions the block has already accepted, oldest first.
    req_t queued_ops[$];
    rsp_t pending_replies[$];

    int ops_accepted = 0;
    int error_count  = 0;
    int cycle_count  = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int send_mode    = 0;
    int recv_mode    = 0;

    // Shadow of the queue contents: cell 0 holds the highest priority.
    logic signed [PRIO_W-1:0]   shadow_prio [DEPTH];
    logic [ITEM_PAYLOAD_W-1:0]  shadow_data [DEPTH];
    int                         shadow_held = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Reset is held at the start and then released for good.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Counts cycles and redraws how much each side idles,
    // so that calm stretches alternate with busy ones.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0)
        begin
            send_mode <= $urandom_range(0, 2);
            recv_mode <= $urandom_range(0, 2);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("sorted_priority_queue_tb: FAIL");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Applies one transaction to the shadow queue and returns the response
    // the block should give for it.
    function automatic rsp_t apply_queue_op(input req_t op);
        rsp_t                       r;
        logic signed [PRIO_W-1:0]   p;
        int                         pos;
        int                         i;
        r = '0;
        p = op.priority_req;
        if (op.kind == OP_INSERT)
        begin
            if (shadow_held >= DEPTH)
                r.full_error = 1'b1;
            else
            begin
                // The new entry goes ahead of the first one that is not
                // strictly higher, which makes ties leave newest first.
                pos = shadow_held;
                for (i = 0; i < shadow_held; i++)
                    if (pos == shadow_held && shadow_prio[i] <= p)
                        pos = i;
                for (i = shadow_held; i > pos; i--)
                begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_data[i] = shadow_data[i-1];
                end
                shadow_prio[pos] = p;
                shadow_data[pos] = op.payload & STORED_MASK;
                shadow_held++;
            end
        end
        else if (shadow_held == 0)
            r.empty_error = 1'b1;
        else
        begin
            r.removed_valid    = 1'b1;
            r.removed_priority = shadow_prio[0];
            r.removed_payload  = shadow_data[0];
            for (i = 0; i + 1 < shadow_held; i++)
            begin
                shadow_prio[i] = shadow_prio[i+1];
                shadow_data[i] = shadow_data[i+1];
            end
            shadow_held--;
        end
        // The head fields read zero whenever the queue ends up empty.
        if (shadow_held > 0)
        begin
            r.head_valid    = 1'b1;
            r.head_priority = shadow_prio[0];
            r.head_payload  = shadow_data[0];
        end
        r.entry_count = shadow_held[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic compare_reply(input rsp_t got, input rsp_t want);
        check_field("removed_valid",    32'(got.removed_valid),    32'(want.removed_valid));
        check_field("removed_priority", 32'(got.removed_priority),
                    32'(want.removed_priority));
        check_field("removed_payload",  got.removed_payload,  want.removed_payload);
        check_field("empty_error",      32'(got.empty_error),      32'(want.empty_error));
        check_field("full_error",       32'(got.full_error),       32'(want.full_error));
        check_field("head_valid",       32'(got.head_valid),       32'(want.head_valid));
        check_field("head_priority",    32'(got.head_priority),    32'(want.head_priority));
        check_field("head_payload",     got.head_payload,     want.head_payload);
        check_field("entry_count",      32'(got.entry_count),      32'(want.entry_count));
    endtask

    // Decides whether an idle burst starts this cycle. Mode 0 never idles,
    // mode 1 idles now and then, mode 2 often. Near the end nobody idles.
    function automatic bit burst_starts(input int mode);
        if (queued_ops.size() <= CALM_TAIL)
            return 1'b0;
        case (mode)
            1:       return $urandom_range(0, 15) == 0;
            2:       return $urandom_range(0, 3) == 0;
            default: return 1'b0;
        endcase
    endfunction

    // Request driver. A transaction counts as taken at an edge where valid
    // is high and stall is low; only then is it run through the shadow
    // queue. While stalled, valid and the payload are left untouched.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            send_gap  <= 0;
        end
        else if (!(req_valid && req_stall))
        begin
            if (req_valid)
            begin
                pending_replies.push_back(apply_queue_op(req));
                ops_accepted <= ops_accepted + 1;
            end
            if (send_gap > 0)
            begin
                send_gap  <= send_gap - 1;
                req_valid <= 1'b0;
            end
            else if (queued_ops.size() != 0 && burst_starts(send_mode))
            begin
                // Starts an idle burst of random length, beginning with this cycle.
                send_gap  <= $urandom_range(0, 6);
                req_valid <= 1'b0;
            end
            else if (queued_ops.size() != 0)
            begin
                req       <= queued_ops.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response monitor. Every response taken is matched against the oldest
    // prediction; the stall it drives comes in bursts like the sender's gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (rsp_valid === 1'b1 && !rsp_stall)
            begin
                if (pending_replies.size() == 0)
                    flag_error("response with no outstanding request");
                else
                    compare_reply(rsp, pending_replies.pop_front());
            end
            if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                rsp_stall <= 1'b1;
            end
            else if (burst_starts(recv_mode))
            begin
                recv_gap  <= $urandom_range(0, 6);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    function automatic req_t make_op(input op_kind_t k, input logic [PRIO_W-1:0] p,
                                     input logic [ITEM_PAYLOAD_W-1:0] d);
        req_t op;
        op.kind         = k;
        op.priority_req = p;
        op.payload      = d;
        return op;
    endfunction

    // Priority styles: a narrow band around zero gives many ties, full range
    // exercises every bit, and the last uses the extremes, their neighbors, 0 and -1.
    function automatic logic [PRIO_W-1:0] pick_priority(input int style);
        int v;
        case (style)
            0:
            begin
                v = $urandom_range(0, 6);
                return PRIO_W'(v - 3);
            end
            1:
                return PRIO_W'($urandom);
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    3:       return 16'shFFFF;
                    4:       return 16'sh8001;
                    default: return 16'sh7FFE;
                endcase
            end
        endcase
    endfunction

    initial
    begin
        int total_ops;
        int insert_pct;
        int run_len;
        int prio_style;
        op_kind_t k;

        // Directed opening: a delete on the empty queue, both priority
        // extremes with all-zero and all-one payloads, three equal
        // priorities to show newest-first among ties, then filling up to a
        // full queue, one insert too many, and a few deletes.
        queued_ops.push_back(make_op(OP_DELETE, 16'sh0000, 32'h0000_0000));
        queued_ops.push_back(make_op(OP_INSERT, 16'sh7FFF, 32'hFFFF_FFFF));
        queued_ops.push_back(make_op(OP_INSERT, 16'sh8000, 32'h0000_0000));
        queued_ops.push_back(make_op(OP_INSERT, 16'sh0005, 32'h0000_000A));
        queued_ops.push_back(make_op(OP_INSERT, 16'sh0005, 32'h0000_000B));
        queued_ops.push_back(make_op(OP_INSERT, 16'sh0005, 32'h0000_000C));
        queued_ops.push_back(make_op(OP_INSERT, 16'sh0000, 32'h5555_5555));
        queued_ops.push_back(make_op(OP_INSERT, 16'shFFFF, 32'hAAAA_AAAA));
        for (int i = 0; i < DEPTH - 7; i++)
            queued_ops.push_back(make_op(OP_INSERT, pick_priority(1), $urandom));
        queued_ops.push_back(make_op(OP_INSERT, 16'sh7FFF, 32'h1234_5678));
        repeat (4)
            queued_ops.push_back(make_op(OP_DELETE, 16'shFFFF, 32'hFFFF_FFFF));

        // Random part, in runs that lean toward filling, draining or
        // neither, so the queue swings between empty and full again and
        // again. Fields a delete ignores still carry random bits.
        total_ops = queued_ops.size() + RANDOM_OPS;
        while (queued_ops.size() < total_ops)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: insert_pct = 85;
                4, 5, 6:    insert_pct = 15;
                default:    insert_pct = 50;
            endcase
            run_len    = $urandom_range(8, 40);
            prio_style = $urandom_range(0, 2);
            repeat (run_len)
            begin
                k = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_DELETE;
                queued_ops.push_back(make_op(k, pick_priority(prio_style), $urandom));
            end
        end
        total_ops = queued_ops.size();

        // Wait for every transaction to be taken and answered, then give
        // the block a little longer to show any response nobody asked for.
        while (ops_accepted < total_ops) @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sorted_priority_queue_tb: PASS");
        else
            $display("sorted_priority_queue_tb: FAIL");
        $finish;
    end

endmodule
